FILE: hw/rtl/fss_pkg.sv
// Shared types, constants and helpers for the fuzzy subsequence scorer
`timescale 1ns / 1ps
`default_nettype none

package fss_pkg;

    // query storage
    localparam int MAX_QUERY_LEN = 32;
    localparam int QUERY_LEN_W   = 6;
    localparam int QUERY_IDX_W   = 5;
    localparam int QUERY_WORDS   = 4;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_QUERY_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_QUERY_0_7    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_QUERY_8_15   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_QUERY_16_23  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_QUERY_24_31  = 3'd4;

    // scoring
    localparam int SCORE_W = 10;
    localparam logic [SCORE_W-1:0] SCORE_MAX      = 10'd1023;
    localparam logic [SCORE_W-1:0] SCORE_EMPTY_Q  = 10'd1;
    localparam logic [SCORE_W-1:0] BONUS_FIRST    = 10'd10;
    localparam logic [4:0]         PTS_HIT        = 5'd1;
    localparam logic [4:0]         PTS_BOUNDARY   = 5'd8;
    localparam logic [4:0]         PTS_CONSEC     = 5'd5;
    localparam logic [3:0]         POS_LIMIT      = 4'd8;

    // separator characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SLASH = 8'h2f;

    // one result request
    typedef struct packed {
        logic               hl;
        logic               done;
        logic               match;
        logic [SCORE_W-1:0] score;
    } result_t;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5a);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7a);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return is_upper(c) ? (c + 8'd32) : c;
    endfunction

    function automatic logic is_separator(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_DASH) || (c == CH_UNDER) ||
               (c == CH_DOT) || (c == CH_SLASH);
    endfunction

    // saturating score add
    function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] a,
                                                   input logic [SCORE_W-1:0] b);
        logic [SCORE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SCORE_W] ? SCORE_MAX : s[SCORE_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fuzzy_subsequence_scorer.sv
// Top level of the fuzzy subsequence scorer
// Streams one text byte per request and matches the configured query greedily as a
// case-insensitive subsequence; each byte gives one result request with its highlight
// flag, and the last byte of a text also carries the verdict and the score. The block
// takes one byte every cycle while text_stall is low: the per-text state (query position,
// score, previous byte) is updated by short logic as each byte is taken, and results are
// registered. An output register plus a one-entry skid stage let input keep flowing
// while a result waits; text_stall rises only when both are full. Configuration writes
// are always ready and must only happen while no text is in flight.
`timescale 1ns / 1ps
`default_nettype none

module fuzzy_subsequence_scorer
    import fss_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [63:0]            cfg_data,

    input  wire logic                   text_valid,
    output logic                        text_stall,
    input  wire logic [7:0]             text_char,
    input  wire logic                   text_start,
    input  wire logic                   text_end,
    input  wire logic                   empty_text,

    output logic                        result_valid,
    input  wire logic                   result_stall,
    output logic                        char_highlighted,
    output logic                        text_done,
    output logic                        is_match,
    output logic [SCORE_W-1:0]          final_score
);

    // configuration registers
    logic [QUERY_LEN_W-1:0] query_length_reg;
    logic [63:0]            query_chars_reg [QUERY_WORDS];

    // per-text state
    logic [QUERY_LEN_W-1:0] query_pos_reg,     query_pos_next;
    logic                   last_was_hit_reg,  last_was_hit_next;
    logic [7:0]             previous_byte_reg, previous_byte_next;
    logic [3:0]             text_pos_reg,      text_pos_next;
    logic [SCORE_W-1:0]     running_score_reg, running_score_next;
    logic                   hit_at_zero_reg,   hit_at_zero_next;

    // output register and skid stage
    result_t out_reg,  skid_reg,  result_next;
    logic    out_valid_reg, skid_valid_reg;

    logic text_accept;
    logic out_free;

    // working values
    logic [QUERY_LEN_W-1:0]      eff_len;
    logic [QUERY_LEN_W-1:0]      cur_qpos;
    logic                        cur_last;
    logic [7:0]                  cur_prev;
    logic [3:0]                  cur_pos;
    logic [SCORE_W-1:0]          cur_score;
    logic                        cur_hz;
    logic [8*MAX_QUERY_LEN-1:0]  query_flat;
    logic [7:0]                  query_byte;
    logic                        active;
    logic                        hit;
    logic                        boundary;
    logic [4:0]                  add_pts;
    logic [SCORE_W-1:0]          hit_score;
    logic [QUERY_LEN_W-1:0]      new_qpos;
    logic                        new_hz;

    assign cfg_ready   = 1'b1;
    assign text_stall  = skid_valid_reg;
    assign text_accept = text_valid && !text_stall;
    assign out_free    = !out_valid_reg || !result_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_length_reg <= '0;
            for (int i = 0; i < QUERY_WORDS; i++)
            begin
                query_chars_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_QUERY_LENGTH: query_length_reg   <= cfg_data[QUERY_LEN_W-1:0];
                REG_QUERY_0_7:    query_chars_reg[0] <= cfg_data;
                REG_QUERY_8_15:   query_chars_reg[1] <= cfg_data;
                REG_QUERY_16_23:  query_chars_reg[2] <= cfg_data;
                REG_QUERY_24_31:  query_chars_reg[3] <= cfg_data;
                default:          ;
            endcase
        end
    end

    // clamp the query length
    assign eff_len = (query_length_reg > QUERY_LEN_W'(MAX_QUERY_LEN))
                   ? QUERY_LEN_W'(MAX_QUERY_LEN) : query_length_reg;

    // a starting byte sees a fresh text
    always_comb
    begin
        if (text_start)
        begin
            cur_qpos  = '0;
            cur_last  = 1'b0;
            cur_prev  = '0;
            cur_pos   = '0;
            cur_score = '0;
            cur_hz    = 1'b0;
        end
        else
        begin
            cur_qpos  = query_pos_reg;
            cur_last  = last_was_hit_reg;
            cur_prev  = previous_byte_reg;
            cur_pos   = text_pos_reg;
            cur_score = running_score_reg;
            cur_hz    = hit_at_zero_reg;
        end
    end

    // next query character
    assign query_flat = {query_chars_reg[3], query_chars_reg[2],
                         query_chars_reg[1], query_chars_reg[0]};
    assign query_byte = query_flat[{cur_qpos[QUERY_IDX_W-1:0], 3'b000} +: 8];

    // match and scoring of this byte
    assign active   = cur_qpos < eff_len;
    assign hit      = active && (to_lower(text_char) == to_lower(query_byte));
    assign boundary = (cur_pos == 4'd0) || is_separator(cur_prev) ||
                      (is_lower(cur_prev) && is_upper(text_char));

    always_comb
    begin
        add_pts = PTS_HIT;
        if (boundary)
        begin
            add_pts = add_pts + PTS_BOUNDARY;
        end
        if (cur_last)
        begin
            add_pts = add_pts + PTS_CONSEC;
        end
        if (cur_pos < POS_LIMIT)
        begin
            add_pts = add_pts + {1'b0, POS_LIMIT - cur_pos};
        end
    end

    assign hit_score = hit ? sat_add(cur_score, SCORE_W'(add_pts)) : cur_score;
    assign new_qpos  = hit ? (cur_qpos + QUERY_LEN_W'(1)) : cur_qpos;
    assign new_hz    = cur_hz || (hit && (cur_pos == 4'd0));

    // next state and result
    always_comb
    begin
        query_pos_next     = new_qpos;
        last_was_hit_next  = active ? hit : cur_last;
        previous_byte_next = text_char;
        text_pos_next      = (cur_pos < POS_LIMIT) ? (cur_pos + 4'd1) : cur_pos;
        running_score_next = hit_score;
        hit_at_zero_next   = new_hz;

        result_next.hl    = hit && !empty_text;
        result_next.done  = empty_text || text_end;
        result_next.match = 1'b0;
        result_next.score = '0;

        if (empty_text || text_end)
        begin
            query_pos_next     = '0;
            last_was_hit_next  = 1'b0;
            previous_byte_next = '0;
            text_pos_next      = '0;
            running_score_next = '0;
            hit_at_zero_next   = 1'b0;
            if (eff_len == '0)
            begin
                result_next.match = 1'b1;
                result_next.score = SCORE_EMPTY_Q;
            end
            else if (!empty_text && (new_qpos >= eff_len))
            begin
                result_next.match = 1'b1;
                result_next.score = sat_add(hit_score, new_hz ? BONUS_FIRST : '0);
            end
        end
    end

    // per-text state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_pos_reg     <= '0;
            last_was_hit_reg  <= 1'b0;
            previous_byte_reg <= '0;
            text_pos_reg      <= '0;
            running_score_reg <= '0;
            hit_at_zero_reg   <= 1'b0;
        end
        else if (text_accept)
        begin
            query_pos_reg     <= query_pos_next;
            last_was_hit_reg  <= last_was_hit_next;
            previous_byte_reg <= previous_byte_next;
            text_pos_reg      <= text_pos_next;
            running_score_reg <= running_score_next;
            hit_at_zero_reg   <= hit_at_zero_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= text_accept;
                end
            end
            else if (text_accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result_next;
        end
        if (!out_free && text_accept)
        begin
            skid_reg <= result_next;
        end
    end

    assign result_valid     = out_valid_reg;
    assign char_highlighted = out_reg.hl;
    assign text_done        = out_reg.done;
    assign is_match         = out_reg.match;
    assign final_score      = out_reg.score;

    // checks
    a_match_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.match |-> out_reg.done)
        else $error("match reported without a verdict");

    a_score_only_on_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.match |-> out_reg.score == '0)
        else $error("nonzero score without a match");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage filled while output register empty");

    a_qpos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        query_pos_reg <= QUERY_LEN_W'(MAX_QUERY_LEN))
        else $error("query position beyond query storage");

endmodule

`default_nettype wire

FILE: tb/sv/fss_score_checker.sv
// Scoreboard for the fuzzy subsequence scorer: tracks the query, predicts every result, compares
`timescale 1ns / 1ps

module fss_score_checker
    import fss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,

    input  logic                   text_valid,
    input  logic                   text_stall,
    input  logic [7:0]             text_char,
    input  logic                   text_start,
    input  logic                   text_end,
    input  logic                   empty_text,

    input  logic                   result_valid,
    input  logic                   result_stall,
    input  logic                   char_highlighted,
    input  logic                   text_done,
    input  logic                   is_match,
    input  logic [SCORE_W-1:0]     final_score,

    output int                     fail_count,
    output int                     pending
);

    // configured query
    logic [QUERY_LEN_W-1:0] q_len;
    logic [63:0]            q_words [QUERY_WORDS];

    // per-text matching state
    logic [QUERY_LEN_W-1:0] q_pos;
    logic                   last_hit;
    logic [7:0]             prev_byte;
    logic [3:0]             t_pos;
    logic [SCORE_W-1:0]     run_score;
    logic                   hit_zero;

    result_t expected_results [$];

    function automatic void restart_text();
        q_pos     = '0;
        last_hit  = 1'b0;
        prev_byte = '0;
        t_pos     = '0;
        run_score = '0;
        hit_zero  = 1'b0;
    endfunction

    function automatic logic [7:0] lower_case(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic [SCORE_W-1:0] add_capped(input logic [SCORE_W-1:0] a,
                                                      input logic [SCORE_W-1:0] b);
        logic [SCORE_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum > {1'b0, SCORE_MAX}) ? SCORE_MAX : sum[SCORE_W-1:0];
    endfunction

    // text start, after a separator, or a lower-to-upper camel step
    function automatic logic starts_word(input logic [7:0] cur);
        if (t_pos == 0)
            return 1'b1;
        if (prev_byte == CH_SPACE || prev_byte == CH_DASH || prev_byte == CH_UNDER ||
            prev_byte == CH_DOT || prev_byte == CH_SLASH)
            return 1'b1;
        return (prev_byte >= "a" && prev_byte <= "z") && (cur >= "A" && cur <= "Z");
    endfunction

    // expected result for one byte request, advances the text state
    function automatic result_t score_byte(input logic [7:0] ch, input logic first,
                                           input logic last, input logic no_byte);
        result_t                r;
        logic [QUERY_LEN_W-1:0] len;
        logic [4:0]             k;
        logic [7:0]             qc;
        logic [SCORE_W-1:0]     pts;
        r   = '0;
        len = (q_len > QUERY_LEN_W'(MAX_QUERY_LEN)) ? QUERY_LEN_W'(MAX_QUERY_LEN) : q_len;
        if (no_byte)
        begin
            restart_text();
            r.done = 1'b1;
            if (len == 0)
            begin
                r.match = 1'b1;
                r.score = SCORE_EMPTY_Q;
            end
        end
        else
        begin
            if (first)
                restart_text();
            if (q_pos < len)
            begin
                k  = q_pos[4:0];
                qc = q_words[k[4:3]][{k[2:0], 3'b000} +: 8];
                if (lower_case(ch) == lower_case(qc))
                begin
                    r.hl = 1'b1;
                    pts  = SCORE_W'(PTS_HIT);
                    if (starts_word(ch))
                        pts = pts + SCORE_W'(PTS_BOUNDARY);
                    if (last_hit)
                        pts = pts + SCORE_W'(PTS_CONSEC);
                    if (t_pos < POS_LIMIT)
                        pts = pts + SCORE_W'(POS_LIMIT - t_pos);
                    if (t_pos == 0)
                        hit_zero = 1'b1;
                    run_score = add_capped(run_score, pts);
                    q_pos     = q_pos + QUERY_LEN_W'(1);
                    last_hit  = 1'b1;
                end
                else
                begin
                    last_hit = 1'b0;
                end
            end
            prev_byte = ch;
            if (t_pos < POS_LIMIT)
                t_pos = t_pos + 4'd1;
            if (last)
            begin
                r.done = 1'b1;
                if (len == 0)
                begin
                    r.match = 1'b1;
                    r.score = SCORE_EMPTY_Q;
                end
                else if (q_pos >= len)
                begin
                    r.match = 1'b1;
                    r.score = add_capped(run_score, hit_zero ? BONUS_FIRST : '0);
                end
                restart_text();
            end
        end
        return r;
    endfunction

    // watch all three channels
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            q_len = '0;
            for (int w = 0; w < QUERY_WORDS; w++)
                q_words[w] = '0;
            restart_text();
            expected_results.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_QUERY_LENGTH: q_len      = cfg_data[QUERY_LEN_W-1:0];
                    REG_QUERY_0_7:    q_words[0] = cfg_data;
                    REG_QUERY_8_15:   q_words[1] = cfg_data;
                    REG_QUERY_16_23:  q_words[2] = cfg_data;
                    REG_QUERY_24_31:  q_words[3] = cfg_data;
                    default: ;
                endcase
            end

            // byte requests
            if (text_valid && !text_stall)
                expected_results = {expected_results,
                                    score_byte(text_char, text_start, text_end, empty_text)};

            // result requests
            if (result_valid && !result_stall)
            begin
                got = '{hl: char_highlighted, done: text_done, match: is_match,
                        score: final_score};
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result hl=%b done=%b match=%b score=%0d",
                             $time, got.hl, got.done, got.match, got.score);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: result mismatch expected hl=%b done=%b match=%b score=%0d",
                                 $time, want.hl, want.done, want.match, want.score);
                        $display("%0t:                  actual   hl=%b done=%b match=%b score=%0d",
                                 $time, got.hl, got.done, got.match, got.score);
                        fail_count++;
                    end
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

FILE: tb/sv/tb_fuzzy_subsequence_scorer.sv
// Testbench top for the fuzzy subsequence scorer: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_fuzzy_subsequence_scorer;
    import fss_pkg::*;

    localparam int BYTE_GOAL   = 1400;
    localparam int HOLD_CYCLES = 80;
    localparam int STUCK_LIMIT = 2000;
    // index past the register file, the block must ignore it
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [63:0]            cfg_data;
    logic                   text_valid;
    logic                   text_stall;
    logic [7:0]             text_char;
    logic                   text_start;
    logic                   text_end;
    logic                   empty_text;
    logic                   result_valid;
    logic                   result_stall;
    logic                   char_highlighted;
    logic                   text_done;
    logic                   is_match;
    logic [SCORE_W-1:0]     final_score;

    int                     fail_count;
    int                     pending;
    int                     bytes_sent;
    int                     tx_rate;
    int                     rx_rate;
    int                     stuck_cycles;
    logic                   quiet;
    logic                   hold_req;
    logic [QUERY_LEN_W-1:0] qlen;
    logic [7:0]             qbuf [MAX_QUERY_LEN];

    fuzzy_subsequence_scorer i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .text_valid       (text_valid),
        .text_stall       (text_stall),
        .text_char        (text_char),
        .text_start       (text_start),
        .text_end         (text_end),
        .empty_text       (empty_text),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .char_highlighted (char_highlighted),
        .text_done        (text_done),
        .is_match         (is_match),
        .final_score      (final_score)
    );

    fss_score_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .text_valid       (text_valid),
        .text_stall       (text_stall),
        .text_char        (text_char),
        .text_start       (text_start),
        .text_end         (text_end),
        .empty_text       (empty_text),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .char_highlighted (char_highlighted),
        .text_done        (text_done),
        .is_match         (is_match),
        .final_score      (final_score),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    // 125 MHz clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog on cycles without any accepted request
    always @(posedge clk)
    begin
        if (!rst_n || (text_valid && !text_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
        begin
            stuck_cycles = 0;
        end
        else
        begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // result side: random stall bursts, one long hold on request
    initial
    begin : result_sink
        int tick;
        tick         = 0;
        rx_rate      = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (tick % 40 == 0)
                rx_rate = $urandom_range(0, 3);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                result_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (!quiet && rx_rate != 0 && $urandom_range(0, 7) < rx_rate)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // one byte request, with an optional idle burst ahead of it
    task automatic send_item(input logic [7:0] ch, input logic st, input logic en,
                             input logic em);
        if (!quiet && tx_rate != 0 && $urandom_range(0, 7) < tx_rate)
        begin
            @(negedge clk);
            text_valid <= 1'b0;
            repeat ($urandom_range(1, 14) - 1) @(negedge clk);
        end
        @(negedge clk);
        text_valid <= 1'b1;
        text_char  <= ch;
        text_start <= st;
        text_end   <= en;
        empty_text <= em;
        do @(posedge clk); while (text_stall);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input logic st, input logic en);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], st && i == 0, en && i == s.len() - 1, 1'b0);
    endtask

    // drain all results before touching registers
    task automatic wait_idle();
        @(negedge clk);
        text_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_query();
        logic [63:0] word;
        write_reg(REG_QUERY_LENGTH, {{(64 - QUERY_LEN_W){1'b0}}, qlen});
        for (int w = 0; w < QUERY_WORDS; w++)
        begin
            for (int b = 0; b < 8; b++)
                word[b * 8 +: 8] = qbuf[w * 8 + b];
            write_reg(CFG_INDEX_W'(REG_QUERY_0_7 + w), word);
        end
    endtask

    // mostly a small letter set so matches are frequent
    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        case ($urandom_range(0, 15))
            0:       c = 8'($urandom_range(0, 255));
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       c = CH_SPACE;
                    1:       c = CH_DASH;
                    2:       c = CH_UNDER;
                    3:       c = CH_DOT;
                    default: c = CH_SLASH;
                endcase
            end
            15:      c = 8'("0" + $urandom_range(0, 9));
            default: c = ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'($urandom_range(0, 5));
        endcase
        return c;
    endfunction

    task automatic pick_query();
        case ($urandom_range(0, 9))
            0:       qlen = '0;
            1:       qlen = QUERY_LEN_W'(MAX_QUERY_LEN);
            2:       qlen = QUERY_LEN_W'($urandom_range(MAX_QUERY_LEN + 1, 63));
            3:       qlen = QUERY_LEN_W'(1);
            default: qlen = QUERY_LEN_W'($urandom_range(2, 6));
        endcase
        for (int i = 0; i < MAX_QUERY_LEN; i++)
            qbuf[i] = pick_char();
    endtask

    // text that holds the query as a subsequence, sometimes with a query byte dropped
    task automatic send_matching_text();
        logic [7:0] txt [$];
        logic [7:0] c;
        int         len;
        int         pad;
        len = (qlen > QUERY_LEN_W'(MAX_QUERY_LEN)) ? MAX_QUERY_LEN : int'(qlen);
        pad = (len > 8) ? 1 : 3;
        for (int i = 0; i < len; i++)
        begin
            repeat ($urandom_range(0, pad)) txt = {txt, pick_char()};
            c = qbuf[i];
            if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1))
                c = c ^ 8'h20;
            if ($urandom_range(0, 15) != 0)
                txt = {txt, c};
        end
        repeat ($urandom_range(0, pad)) txt = {txt, pick_char()};
        if (txt.size() == 0)
        begin
            send_item(pick_char(), 1'b1, 1'b1, 1'b1);
        end
        else
        begin
            for (int i = 0; i < txt.size(); i++)
                send_item(txt[i], i == 0 && $urandom_range(0, 7) != 0,
                          i == txt.size() - 1, 1'b0);
        end
    endtask

    // random bytes and flags: stray starts and ends, empty items, open texts
    task automatic send_noise_text();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            send_item(8'($urandom_range(0, 255)),
                      (i == 0) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 7) == 0),
                      (i == n - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 11) == 0),
                      $urandom_range(0, 9) == 0);
    endtask

    initial
    begin
        int phase;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        text_valid = 1'b0;
        text_char  = '0;
        text_start = 1'b0;
        text_end   = 1'b0;
        empty_text = 1'b0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        tx_rate    = 0;
        bytes_sent = 0;
        qlen       = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // empty query, register extremes, spare index ignored
        write_reg(REG_QUERY_LENGTH, 64'd0);
        write_reg(REG_QUERY_0_7, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_QUERY_8_15, 64'd0);
        write_reg(REG_QUERY_16_23, 64'd0);
        write_reg(REG_QUERY_24_31, 64'd0);
        write_reg(REG_SPARE, {$urandom, $urandom});
        send_item(8'hFF, 1'b1, 1'b1, 1'b1);
        send_text("x", 1'b1, 1'b1);

        // query "ab"
        wait_idle();
        pick_query();
        qbuf[0] = "a";
        qbuf[1] = "b";
        qlen    = QUERY_LEN_W'(2);
        load_query();
        send_text("Ab", 1'b1, 1'b1);
        // missing start after an end, separators, byte extremes
        send_item(8'h00, 1'b0, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0, 1'b0);
        send_text(".a_b", 1'b0, 1'b1);
        // hits past the position window, camel step
        send_text("zzzzzzzzaB", 1'b1, 1'b1);
        // empty text against a non-empty query
        send_item("a", 1'b0, 1'b1, 1'b1);
        // incomplete match
        send_text("a", 1'b1, 1'b1);
        // query shortened while a text is open
        send_text("a", 1'b1, 1'b0);
        wait_idle();
        write_reg(REG_QUERY_LENGTH, 64'd1);
        send_text("q", 1'b0, 1'b1);

        // random phases, each with a fresh query
        phase = 0;
        while (bytes_sent < BYTE_GOAL)
        begin
            wait_idle();
            if (bytes_sent > BYTE_GOAL * 9 / 10)
                quiet = 1'b1;
            pick_query();
            load_query();
            tx_rate = $urandom_range(0, 4);
            if (phase == 3)
                hold_req = 1'b1;
            repeat ($urandom_range(4, 10))
            begin
                case ($urandom_range(0, 9))
                    7, 8:    send_noise_text();
                    9:       send_item(8'($urandom_range(0, 255)),
                                       $urandom_range(0, 1) == 1,
                                       $urandom_range(0, 1) == 1, 1'b1);
                    default: send_matching_text();
                endcase
            end
            phase++;
        end

        wait_idle();
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
